[hw/rtl/rwnh_pkg.sv]
// Shared types and constants for the ray/wall nearest-hit block.
// No dependencies; used by rwnh_div and ray_wall_nearest_hit.
`default_nettype none

package rwnh_pkg;

  localparam int unsigned CoordW   = 16;  // Q12.4 coordinate width
  localparam int unsigned DiffW    = 17;  // coordinate difference
  localparam int unsigned MulW     = 18;  // shared multiplier operand width
  localparam int unsigned ProdW    = 36;  // shared multiplier product width
  localparam int unsigned AccW     = 36;  // den, sn, tn cross products
  localparam int unsigned TW       = 33;  // saturated ray distance t
  localparam int unsigned RemW     = 35;  // divider partial remainder
  localparam int unsigned PtW      = 52;  // t * dir accumulator
  localparam int unsigned DirFrac  = 14;  // fraction bits of the direction
  localparam int unsigned StepW    = 3;
  localparam int unsigned EdgeProds  = 6;
  localparam int unsigned PointProds = 4;
  // t overflows TW bits when tn >= den * 2^(TW - DirFrac)
  localparam int unsigned OvfShift = TW - DirFrac;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_NORM,
    ST_TEST,
    ST_DIV,
    ST_POINT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_DIR_X,
    REG_DIR_Y
  } cfg_reg_e;

  // Request to the serial divider
  typedef struct packed {
    logic                start;
    logic [RemW-1:0]     rem_init;
    logic [TW-1:0]       num_lo;
    logic [RemW-1:0]     den;
  } div_req_t;

endpackage

`default_nettype wire

[hw/rtl/rwnh_div.sv]
// Restoring divider, one quotient bit per cycle, for the ray distance.
// Depends on rwnh_pkg.
`default_nettype none

module rwnh_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rwnh_pkg::div_req_t     req_i,
  output logic                        done_o,
  output logic [rwnh_pkg::TW-1:0]     quot_o
);

  localparam int unsigned CntW = $clog2(rwnh_pkg::TW + 1);

  logic [rwnh_pkg::RemW-1:0] rem_q, rem_d, trial;
  logic [rwnh_pkg::TW-1:0]   quo_q, quo_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic                      ge;

  // Shift the next dividend bit in, subtract when it fits
  assign trial = {rem_q[rwnh_pkg::RemW-2:0], quo_q[rwnh_pkg::TW-1]};
  assign ge    = (trial >= req_i.den);

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      quo_d  = req_i.num_lo;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (trial - req_i.den) : trial;
      quo_d = {quo_q[rwnh_pkg::TW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(rwnh_pkg::TW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[hw/rtl/ray_wall_nearest_hit.sv]
// Top level of the ray/wall nearest-hit block: sequencer, shared multiplier,
// result register. Depends on rwnh_pkg and rwnh_div.
//
//   channel   dir  tdata (low bit up)                        tuser       tlast
//   s_axis    in   wall_start_x, wall_start_y, wall_end_x,   first_wall  last_wall
//                  wall_end_y
//   m_axis    out  hit_x, hit_y, hit_distance                hit_valid   cast_done
//   cfg       in   write port: index 0..3 = origin_x, origin_y, dir_x, dir_y
//
// A wall that misses skips the divide and the point products; a hit whose distance
// overflows skips only the divide. The pace is set by the 33-step serial divider
// and the one 18x18 multiplier that serves all six cross products and four point
// products in turn. s_axis_tready is high only between items. The result register
// lets the next wall transfer in while a result waits; a full register stalls the
// finish step while m_axis_tready is low. Reset sets origin 0, direction (1.0, 0)
// and clears the nearest hit.
`default_nettype none

module ray_wall_nearest_hit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // wall_start_x, wall_start_y, wall_end_x, wall_end_y
  input  wire logic [63:0] s_axis_tdata,
  // first_wall
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // hit_x, hit_y, hit_distance
  output logic [47:0]      m_axis_tdata,
  // hit_valid
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned SumW = 38;

  rwnh_pkg::state_e state_q, state_d;

  // Configuration
  logic signed [15:0] origin_x_q, origin_y_q, dir_x_q, dir_y_q;

  // Per-item working registers
  logic signed [rwnh_pkg::DiffW-1:0] wx_q, wy_q, ex_q, ey_q;
  logic                              last_q;
  logic signed [rwnh_pkg::AccW-1:0]  den_q, sn_q, tn_q;
  logic signed [rwnh_pkg::PtW-1:0]   px_q, py_q;
  logic [rwnh_pkg::TW-1:0]           t_q;
  logic                              hit_q;
  logic [rwnh_pkg::StepW-1:0]        step_q, step_d;

  // Shared multiplier and its product register
  logic signed [rwnh_pkg::MulW-1:0]  mul_a, mul_b;
  logic signed [rwnh_pkg::ProdW-1:0] prod_c, prod_q;
  logic                              prod_vld_q, prod_pt_q;
  logic [rwnh_pkg::StepW-1:0]        prod_idx_q;

  // Nearest-hit state
  logic        have_hit_q;
  logic [15:0] best_dist_q, best_x_q, best_y_q;

  // Result register
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_user_q, out_last_q;

  // Sequencer controls
  logic in_xfer, issue, div_start, fin_go, cand, ovf;
  rwnh_pkg::div_req_t                div_req;
  logic                              div_done;
  logic [rwnh_pkg::TW-1:0]           div_quot;

  // Finish-step values
  logic [15:0] dist_c, ptx_c, pty_c;
  logic        take_c;
  logic        have_d;
  logic [15:0] best_dist_d, best_x_d, best_y_d;
  logic signed [rwnh_pkg::PtW-1:0] px_sh, py_sh;
  logic signed [SumW-1:0]          sum_x, sum_y;

  function automatic logic signed [rwnh_pkg::DiffW-1:0] sub17(
    input logic [15:0] a,
    input logic [15:0] b
  );
    return {a[15], a} - {b[15], b};
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [SumW-1:0] v);
    logic [15:0] r;
    if (v > SumW'(32767)) begin
      r = 16'h7fff;
    end else if (v < -SumW'(32768)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rwnh_pkg::ST_IDLE:  if (in_xfer) state_d = rwnh_pkg::ST_EDGE;
      rwnh_pkg::ST_EDGE:  begin
        if (step_q == rwnh_pkg::StepW'(rwnh_pkg::EdgeProds)) state_d = rwnh_pkg::ST_NORM;
      end
      rwnh_pkg::ST_NORM:  state_d = rwnh_pkg::ST_TEST;
      rwnh_pkg::ST_TEST:  begin
        if (!cand)     state_d = rwnh_pkg::ST_FIN;
        else if (ovf)  state_d = rwnh_pkg::ST_POINT;
        else           state_d = rwnh_pkg::ST_DIV;
      end
      rwnh_pkg::ST_DIV:   if (div_done) state_d = rwnh_pkg::ST_POINT;
      rwnh_pkg::ST_POINT: begin
        if (step_q == rwnh_pkg::StepW'(rwnh_pkg::PointProds)) state_d = rwnh_pkg::ST_FIN;
      end
      rwnh_pkg::ST_FIN:   if (fin_go) state_d = rwnh_pkg::ST_IDLE;
      default:            state_d = rwnh_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    div_start     = 1'b0;
    fin_go        = 1'b0;
    step_d        = '0;
    unique case (state_q)
      rwnh_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      rwnh_pkg::ST_EDGE:  begin
        issue  = (step_q < rwnh_pkg::StepW'(rwnh_pkg::EdgeProds));
        step_d = step_q + rwnh_pkg::StepW'(1);
      end
      rwnh_pkg::ST_TEST:  div_start = cand && !ovf;
      rwnh_pkg::ST_POINT: begin
        issue  = (step_q < rwnh_pkg::StepW'(rwnh_pkg::PointProds));
        step_d = step_q + rwnh_pkg::StepW'(1);
      end
      rwnh_pkg::ST_FIN:   fin_go = !out_valid_q || m_axis_tready;
      default:            ;
    endcase
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Hit test on the sign-normalized cross products
  assign cand = (den_q != '0) && !sn_q[rwnh_pkg::AccW-1] && (sn_q <= den_q)
                && !tn_q[rwnh_pkg::AccW-1];
  assign ovf  = (rwnh_pkg::AccW'(tn_q[rwnh_pkg::AccW-1:rwnh_pkg::OvfShift]) >= den_q);

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == rwnh_pkg::ST_POINT) begin
      // t split into a 17-bit low part and a 16-bit high part
      mul_a = step_q[0] ? {2'b00, t_q[rwnh_pkg::TW-1:17]} : {1'b0, t_q[16:0]};
      mul_b = step_q[1] ? {{2{dir_y_q[15]}}, dir_y_q} : {{2{dir_x_q[15]}}, dir_x_q};
    end else begin
      case (step_q)
        3'd0: begin mul_a = {{2{dir_x_q[15]}}, dir_x_q}; mul_b = {ey_q[16], ey_q}; end
        3'd1: begin mul_a = {{2{dir_y_q[15]}}, dir_y_q}; mul_b = {ex_q[16], ex_q}; end
        3'd2: begin mul_a = {wx_q[16], wx_q}; mul_b = {{2{dir_y_q[15]}}, dir_y_q}; end
        3'd3: begin mul_a = {wy_q[16], wy_q}; mul_b = {{2{dir_x_q[15]}}, dir_x_q}; end
        3'd4: begin mul_a = {wx_q[16], wx_q}; mul_b = {ey_q[16], ey_q}; end
        3'd5: begin mul_a = {wy_q[16], wy_q}; mul_b = {ex_q[16], ex_q}; end
        default: ;
      endcase
    end
  end

  assign prod_c = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Divider
  // ---------------------------------------------------------------------------
  always_comb begin
    div_req.start    = div_start;
    div_req.rem_init = rwnh_pkg::RemW'(tn_q[rwnh_pkg::AccW-1:rwnh_pkg::OvfShift]);
    div_req.num_lo   = {tn_q[rwnh_pkg::OvfShift-1:0], rwnh_pkg::DirFrac'(0)};
    div_req.den      = den_q[rwnh_pkg::RemW-1:0];
  end

  rwnh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Finish step: hit point, distance, nearest-hit update
  // ---------------------------------------------------------------------------
  always_comb begin
    px_sh  = px_q >>> rwnh_pkg::DirFrac;
    py_sh  = py_q >>> rwnh_pkg::DirFrac;
    sum_x  = px_sh[SumW-1:0] + SumW'(origin_x_q);
    sum_y  = py_sh[SumW-1:0] + SumW'(origin_y_q);
    ptx_c  = clamp16(sum_x);
    pty_c  = clamp16(sum_y);
    dist_c = (t_q[rwnh_pkg::TW-1:16] != '0) ? 16'hffff : t_q[15:0];
    take_c = hit_q && (!have_hit_q || dist_c <= best_dist_q);
    have_d      = have_hit_q;
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    if (take_c) begin
      have_d      = 1'b1;
      best_dist_d = dist_c;
      best_x_d    = ptx_c;
      best_y_d    = pty_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rwnh_pkg::ST_IDLE;
      step_q      <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      dir_x_q     <= 16'sd16384;
      dir_y_q     <= '0;
      have_hit_q  <= 1'b0;
      best_dist_q <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      prod_vld_q <= issue;
      if (cfg_we_i) begin
        unique case (rwnh_pkg::cfg_reg_e'(cfg_addr_i))
          rwnh_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data_i;
          rwnh_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
          rwnh_pkg::REG_DIR_X:    dir_x_q    <= cfg_data_i;
          rwnh_pkg::REG_DIR_Y:    dir_y_q    <= cfg_data_i;
          default:                ;
        endcase
      end
      if (in_xfer && s_axis_tuser) begin
        have_hit_q  <= 1'b0;
        best_dist_q <= '0;
        best_x_q    <= '0;
        best_y_q    <= '0;
      end else if (fin_go) begin
        have_hit_q  <= have_d;
        best_dist_q <= best_dist_d;
        best_x_q    <= best_x_d;
        best_y_q    <= best_y_d;
      end
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      wx_q   <= sub17(s_axis_tdata[15:0],  origin_x_q);
      wy_q   <= sub17(s_axis_tdata[31:16], origin_y_q);
      ex_q   <= sub17(s_axis_tdata[47:32], s_axis_tdata[15:0]);
      ey_q   <= sub17(s_axis_tdata[63:48], s_axis_tdata[31:16]);
      last_q <= s_axis_tlast;
    end

    prod_q     <= prod_c;
    prod_pt_q  <= (state_q == rwnh_pkg::ST_POINT);
    prod_idx_q <= step_q;

    // Accumulate the product issued in the previous cycle
    if (prod_vld_q) begin
      if (prod_pt_q) begin
        case (prod_idx_q)
          3'd0:    px_q <= rwnh_pkg::PtW'(prod_q);
          3'd1:    px_q <= px_q + (rwnh_pkg::PtW'(prod_q) <<< 17);
          3'd2:    py_q <= rwnh_pkg::PtW'(prod_q);
          default: py_q <= py_q + (rwnh_pkg::PtW'(prod_q) <<< 17);
        endcase
      end else begin
        case (prod_idx_q)
          3'd0:    den_q <= prod_q;
          3'd1:    den_q <= den_q - prod_q;
          3'd2:    sn_q  <= prod_q;
          3'd3:    sn_q  <= sn_q - prod_q;
          3'd4:    tn_q  <= prod_q;
          default: tn_q  <= tn_q - prod_q;
        endcase
      end
    end else if (state_q == rwnh_pkg::ST_NORM && den_q[rwnh_pkg::AccW-1]) begin
      // Flip all three so the divisor is positive
      den_q <= -den_q;
      sn_q  <= -sn_q;
      tn_q  <= -tn_q;
    end

    if (state_q == rwnh_pkg::ST_TEST) begin
      hit_q <= cand;
      if (ovf) begin
        t_q <= '1;
      end
    end else if (div_done) begin
      t_q <= div_quot;
    end

    if (fin_go) begin
      out_data_q <= {have_d ? best_dist_d : 16'h0000,
                     have_d ? best_y_d : origin_y_q,
                     have_d ? best_x_d : origin_x_q};
      out_user_q <= have_d;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rwnh_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_no_hit_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[47:32] == 16'h0000))
    else $error("distance reported without a hit");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("stalled result dropped");

endmodule

`default_nettype wire
